// ===== hw/rtl/fdra_pkg.sv =====
// Shared types, constants and helpers for the FEM diffusion row assembler.
package fdra_pkg;

    localparam int GRID_W         = 32;
    localparam int ENTRY_W        = 48;
    localparam int IDX_W          = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int OUT_FRAC       = 24;
    localparam int PROD_W         = 64;
    localparam int NUM_W          = PROD_W + OUT_FRAC;
    localparam int TERM_W         = 57;
    localparam int ACC_W          = 60;
    localparam int DIV3_RECIP     = 174763;    // ceil(2^19 / 3)
    localparam int DIV3_SHIFT     = 19;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SIGMA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd2;

    typedef enum logic [2:0] {
        TERM_D_LEFT,
        TERM_P_LEFT,
        TERM_D_RIGHT,
        TERM_P_RIGHT,
        TERM_DONE
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEL,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  advance;
        logic  load_single;
        logic  load_row_a;
        logic  load_row_b;
        logic  mul_go;
        logic  div_start;
        logic  acc_go;
        logic  out_load;
        term_t term;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first;
        logic item_last;
        logic has_l;
        logic has_r;
        logic row_last;
        logic skip;
        logic div_done;
        logic div_idle;
        logic out_taken;
    } dp_sts_t;

    // saturate an accumulator to the signed entry range
    function automatic logic [ENTRY_W-1:0] sat_entry(input logic [ACC_W-1:0] v);
        logic [ACC_W-ENTRY_W:0] top;
        logic [ENTRY_W-1:0]     res;
        top = v[ACC_W-1:ENTRY_W-1];
        if (top == '0 || top == '1)
            res = v[ENTRY_W-1:0];
        else if (v[ACC_W-1])
            res = {1'b1, {(ENTRY_W-1){1'b0}}};
        else
            res = {1'b0, {(ENTRY_W-1){1'b1}}};
        return res;
    endfunction

endpackage

// ===== hw/rtl/fdra_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^56.
module fdra_div
    import fdra_pkg::*;
#(
    parameter int DEN_W = 49
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              idle,
    output logic              done,
    output logic [TERM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] shr_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             over;

    assign trial = {rem_reg, shr_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shr_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            shr_reg <= {shr_reg[NUM_W-2:0], fits};
        end
    end

    assign over = (|shr_reg[NUM_W-1:TERM_W]) ||
                  (shr_reg[TERM_W-1] && (|shr_reg[TERM_W-2:0]));
    assign quot = over ? {1'b1, {(TERM_W-1){1'b0}}} : shr_reg[TERM_W-1:0];
    assign idle = !busy_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/fdra_dp.sv =====
// Datapath: config, grid history, term operands, multiplier, divider, accumulators, output word.
module fdra_dp
    import fdra_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GRID_W-1:0]         cfg_data,
    input  logic signed [GRID_W-1:0]  grid_point,
    input  logic                      last_point,
    input  logic                      out_ready,
    input  ctrl_cmd_t                 cmd,
    output dp_sts_t                   sts,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          row_index,
    output logic signed [ENTRY_W-1:0] sub_entry,
    output logic signed [ENTRY_W-1:0] diag_entry,
    output logic signed [ENTRY_W-1:0] super_entry,
    output logic                      spacing_error,
    output logic                      last_row
);

    localparam int N_W   = $clog2(MAX_POINTS) + 1;
    localparam int DEN_W = GRID_W + FRAC_BITS + 1;
    localparam int HG_W  = GRID_W + OUT_FRAC;

    logic signed [GRID_W-1:0] sigma_reg, gamma_reg, lambda_reg;
    logic signed [GRID_W-1:0] prev_reg, older_reg, x_reg;
    logic [N_W-1:0]           n_reg;
    logic                     item_last_reg;

    logic signed [GRID_W-1:0] xl_reg, xc_reg, xr_reg;
    logic                     has_l_reg, has_r_reg, row_last_reg, bad_reg;
    logic [N_W-1:0]           idx_reg;
    logic signed [ACC_W-1:0]  sub_reg, dia_reg, sup_reg;

    logic [PROD_W-1:0]        prod_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg, skip_reg;
    term_t                    kind_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         row_index_reg;
    logic [ENTRY_W-1:0]       sub_out_reg, dia_out_reg, sup_out_reg;
    logic                     err_out_reg, last_out_reg;

    // half gamma, shared by every row
    logic [GRID_W-1:0]        gam_mag;
    logic [HG_W-1:0]          hg_mag;
    logic signed [ACC_W-1:0]  hg;

    assign gam_mag = gamma_reg[GRID_W-1] ? GRID_W'(-gamma_reg) : gamma_reg;
    assign hg_mag  = {gam_mag, {OUT_FRAC{1'b0}}} >> (FRAC_BITS + 1);
    assign hg      = gamma_reg[GRID_W-1] ? -$signed(ACC_W'(hg_mag)) : $signed(ACC_W'(hg_mag));

    // term operands
    logic                     is_d, is_left;
    logic signed [GRID_W:0]   h_sel;
    logic                     h_bad;
    logic signed [GRID_W+2:0] xc35, xo35, c_val;
    logic [GRID_W+1:0]        c_mag;
    logic [GRID_W-1:0]        sig_mag, lam_mag, mul_a;
    logic [GRID_W+1:0]        mul_b;
    logic [2*GRID_W+1:0]      product;
    logic signed [GRID_W-1:0] x_other;

    assign is_d    = (cmd.term == TERM_D_LEFT) || (cmd.term == TERM_D_RIGHT);
    assign is_left = (cmd.term == TERM_D_LEFT) || (cmd.term == TERM_P_LEFT);
    assign x_other = is_left ? xl_reg : xr_reg;
    assign h_sel   = is_left ? ({xc_reg[GRID_W-1], xc_reg} - {xl_reg[GRID_W-1], xl_reg})
                             : ({xr_reg[GRID_W-1], xr_reg} - {xc_reg[GRID_W-1], xc_reg});
    assign h_bad   = h_sel[GRID_W] || (h_sel == '0);
    assign xc35    = {{3{xc_reg[GRID_W-1]}}, xc_reg};
    assign xo35    = {{3{x_other[GRID_W-1]}}, x_other};
    assign c_val   = (xc35 <<< 1) + xo35;
    assign c_mag   = c_val[GRID_W+2] ? (GRID_W+2)'(-c_val) : c_val[GRID_W+1:0];
    assign sig_mag = sigma_reg[GRID_W-1] ? GRID_W'(-sigma_reg) : sigma_reg;
    assign lam_mag = lambda_reg[GRID_W-1] ? GRID_W'(-lambda_reg) : lambda_reg;
    assign mul_a   = is_d ? sig_mag : lam_mag;
    assign mul_b   = is_d ? {2'b00, sig_mag} : c_mag;
    assign product = mul_a * mul_b;

    // divider
    logic              div_done, div_idle;
    logic [TERM_W-1:0] quot;
    logic signed [ACC_W-1:0] term_val;

    // drift terms divide by the constant 6 * 2^(2*FRAC_BITS): drop the power of two,
    // then divide by three one 16-bit digit per cycle with a reciprocal multiply
    localparam int D3_DIG = (NUM_W + 15) / 16;
    localparam int D3_W   = D3_DIG * 16;
    localparam int D3_SH  = 2 * FRAC_BITS + 1;

    logic              kind_d;
    logic              gen_done, gen_idle;
    logic              d3_busy_reg, d3_done_reg;
    logic [2:0]        d3_cnt_reg;
    logic [1:0]        d3_rem_reg;
    logic [D3_W-1:0]   d3_num_reg, d3_quo_reg;
    logic [17:0]       d3_t;
    logic [35:0]       d3_prod;
    logic [15:0]       d3_digit;
    logic [1:0]        d3_r;
    logic              d3_over;
    logic [TERM_W-1:0] d3_quot, term_mag;

    assign kind_d = (kind_reg == TERM_D_LEFT) || (kind_reg == TERM_D_RIGHT);

    fdra_div #(.DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start && kind_d),
        .num   ({prod_reg, {OUT_FRAC{1'b0}}}),
        .den   (den_reg),
        .idle  (gen_idle),
        .done  (gen_done),
        .quot  (quot)
    );

    // remainder stays below 3, so each quotient digit fits 16 bits
    assign d3_t     = {d3_rem_reg, d3_num_reg[D3_W-1 -: 16]};
    assign d3_prod  = d3_t * 18'(DIV3_RECIP);
    assign d3_digit = d3_prod[DIV3_SHIFT +: 16];
    assign d3_r     = 2'(d3_t - 18'(d3_digit) * 18'd3);
    assign d3_over  = (|d3_quo_reg[D3_W-1:TERM_W]) ||
                      (d3_quo_reg[TERM_W-1] && (|d3_quo_reg[TERM_W-2:0]));
    assign d3_quot  = d3_over ? {1'b1, {(TERM_W-1){1'b0}}} : d3_quo_reg[TERM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d3_busy_reg <= 1'b0;
            d3_done_reg <= 1'b0;
            d3_cnt_reg  <= '0;
        end
        else
        begin
            d3_done_reg <= d3_busy_reg && (d3_cnt_reg == 3'd1);
            if (cmd.div_start && !kind_d)
            begin
                d3_busy_reg <= 1'b1;
                d3_cnt_reg  <= 3'(D3_DIG);
            end
            else if (d3_busy_reg)
            begin
                d3_cnt_reg <= d3_cnt_reg - 3'd1;
                if (d3_cnt_reg == 3'd1)
                    d3_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start && !kind_d)
        begin
            d3_num_reg <= D3_W'({prod_reg, {OUT_FRAC{1'b0}}} >> D3_SH);
            d3_rem_reg <= '0;
            d3_quo_reg <= '0;
        end
        else if (d3_busy_reg)
        begin
            d3_num_reg <= {d3_num_reg[D3_W-17:0], 16'h0000};
            d3_rem_reg <= d3_r;
            d3_quo_reg <= {d3_quo_reg[D3_W-17:0], d3_digit};
        end
    end

    assign div_done = gen_done || d3_done_reg;
    assign div_idle = gen_idle && !d3_busy_reg;
    assign term_mag = kind_d ? quot : d3_quot;
    assign term_val = neg_reg ? -$signed(ACC_W'(term_mag)) : $signed(ACC_W'(term_mag));

    // config and grid history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg  <= '0;
            gamma_reg  <= '0;
            lambda_reg <= '0;
            prev_reg   <= '0;
            older_reg  <= '0;
            n_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SIGMA:  sigma_reg  <= cfg_data;
                    REG_GAMMA:  gamma_reg  <= cfg_data;
                    REG_LAMBDA: lambda_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.advance)
            begin
                if (item_last_reg)
                begin
                    prev_reg  <= '0;
                    older_reg <= '0;
                    n_reg     <= '0;
                end
                else
                begin
                    older_reg <= prev_reg;
                    prev_reg  <= x_reg;
                    n_reg     <= n_reg + N_W'(1);
                end
            end
        end
    end

    // captured word, row set-up, terms and accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg         <= grid_point;
            item_last_reg <= last_point || (n_reg >= N_W'(MAX_POINTS - 1));
        end
        if (cmd.load_single)
        begin
            has_l_reg    <= 1'b0;
            has_r_reg    <= 1'b0;
            row_last_reg <= 1'b1;
            idx_reg      <= '0;
            bad_reg      <= 1'b0;
            sub_reg      <= '0;
            dia_reg      <= '0;
            sup_reg      <= '0;
        end
        else if (cmd.load_row_a)
        begin
            xl_reg       <= older_reg;
            xc_reg       <= prev_reg;
            xr_reg       <= x_reg;
            has_l_reg    <= n_reg >= N_W'(2);
            has_r_reg    <= 1'b1;
            row_last_reg <= 1'b0;
            idx_reg      <= n_reg - N_W'(1);
            bad_reg      <= 1'b0;
            sub_reg      <= (n_reg >= N_W'(2)) ? -hg : '0;
            dia_reg      <= '0;
            sup_reg      <= hg;
        end
        else if (cmd.load_row_b)
        begin
            xl_reg       <= prev_reg;
            xc_reg       <= x_reg;
            has_l_reg    <= 1'b1;
            has_r_reg    <= 1'b0;
            row_last_reg <= 1'b1;
            idx_reg      <= n_reg;
            bad_reg      <= 1'b0;
            sub_reg      <= -hg;
            dia_reg      <= '0;
            sup_reg      <= '0;
        end
        else if (cmd.mul_go)
        begin
            prod_reg <= product[PROD_W-1:0];
            den_reg  <= DEN_W'(h_sel[GRID_W-1:0]) << (FRAC_BITS + 1);
            neg_reg  <= is_d ? 1'b0 : (lambda_reg[GRID_W-1] ^ c_val[GRID_W+2]);
            skip_reg <= is_d && h_bad;
            kind_reg <= cmd.term;
            if (is_d && h_bad)
                bad_reg <= 1'b1;
        end
        else if (cmd.acc_go)
        begin
            case (kind_reg)
                TERM_D_LEFT, TERM_P_LEFT:
                begin
                    dia_reg <= dia_reg - term_val;
                    sub_reg <= sub_reg + term_val;
                end
                TERM_D_RIGHT:
                begin
                    dia_reg <= dia_reg - term_val;
                    sup_reg <= sup_reg + term_val;
                end
                TERM_P_RIGHT:
                begin
                    dia_reg <= dia_reg + term_val;
                    sup_reg <= sup_reg - term_val;
                end
                default: ;
            endcase
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_index_reg <= IDX_W'(idx_reg);
            sub_out_reg   <= sat_entry(sub_reg);
            dia_out_reg   <= sat_entry(dia_reg);
            sup_out_reg   <= sat_entry(sup_reg);
            err_out_reg   <= bad_reg;
            last_out_reg  <= row_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_index     = row_index_reg;
    assign sub_entry     = sub_out_reg;
    assign diag_entry    = dia_out_reg;
    assign super_entry   = sup_out_reg;
    assign spacing_error = err_out_reg;
    assign last_row      = last_out_reg;

    assign sts.first     = (n_reg == '0);
    assign sts.item_last = item_last_reg;
    assign sts.has_l     = has_l_reg;
    assign sts.has_r     = has_r_reg;
    assign sts.row_last  = row_last_reg;
    assign sts.skip      = skip_reg;
    assign sts.div_done  = div_done;
    assign sts.div_idle  = div_idle;
    assign sts.out_taken = out_valid_reg && out_ready;

endmodule

// ===== hw/rtl/fdra_ctrl.sv =====
// Controller: sequences capture, row set-up, the four terms of a row and the output word.
module fdra_ctrl
    import fdra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    term_t  term_reg, term_next;
    logic   present;

    assign present = ((term_reg == TERM_D_LEFT) || (term_reg == TERM_P_LEFT)) ? sts.has_l
                                                                              : sts.has_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_D_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                term_next = TERM_D_LEFT;
                if (sts.first && !sts.item_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SEL;
            end
            ST_SEL:
                if (term_reg == TERM_DONE)
                    state_next = ST_EMIT;
                else if (present)
                    state_next = ST_MUL;
                else
                    term_next = term_t'(term_reg + 3'd1);
            ST_MUL:
                state_next = ST_DIV_GO;
            ST_DIV_GO:
                if (sts.skip)
                begin
                    term_next  = term_t'(term_reg + 3'd1);
                    state_next = ST_SEL;
                end
                else
                    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (sts.div_done)
                begin
                    term_next  = term_t'(term_reg + 3'd1);
                    state_next = ST_SEL;
                end
            ST_EMIT:
                state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (sts.out_taken)
                begin
                    if (!sts.row_last && sts.item_last)
                    begin
                        term_next  = TERM_D_LEFT;
                        state_next = ST_SEL;
                    end
                    else
                        state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.term = term_reg;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE:
                if (sts.first && sts.item_last)
                    cmd.load_single = 1'b1;
                else if (sts.first)
                    cmd.advance = 1'b1;
                else
                    cmd.load_row_a = 1'b1;
            ST_MUL:
                cmd.mul_go = 1'b1;
            ST_DIV_GO:
                cmd.div_start = !sts.skip;
            ST_DIV_WAIT:
                cmd.acc_go = sts.div_done;
            ST_EMIT:
                cmd.out_load = 1'b1;
            ST_OUT_WAIT:
                if (sts.out_taken)
                begin
                    if (!sts.row_last && sts.item_last)
                        cmd.load_row_b = 1'b1;
                    else
                        cmd.advance = 1'b1;
                end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/fem_diffusion_row_assembly.sv =====
// Top level of the streaming 1D FEM diffusion stiffness row assembler.
//
// Grid nodes come in one word at a time (grid_point, signed Q16.16, ascending;
// last_point marks the final node). Once a node's right-hand neighbour is in,
// one row word of the tridiagonal stiffness matrix comes out: sub, diagonal
// and super entries in signed Q24.24, saturated to 48 bits, with row_index,
// spacing_error (a spacing used by the row was zero or negative; its
// diffusion term then counts as zero) and last_row. The last node gives two
// row words, a single-node grid one row of zeros. A node that would be number
// MAX_POINTS-1 closes the grid whatever last_point says. Registers 0..2 hold
// sigma, gamma and lambda (signed Q16.16, reset 0); write them only while the
// block is idle. cfg_ready is always high.
// Timing: one word is worked at a time. Each row is built from up to four
// terms, one after another. The two sigma^2/(2h) terms go through a restoring
// divider that retires one of 88 quotient bits per cycle; the two
// lambda*(2xc+xo)/6 terms go through a divide-by-three unit that retires a
// 16-bit digit per cycle. A bad spacing skips the divider for its term, and
// output back-pressure holds the block until the row word is taken.
// in_ready is high only between words; results wait in an output register.
module fem_diffusion_row_assembly
    import fdra_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GRID_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [GRID_W-1:0]  grid_point,
    input  logic                      last_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [IDX_W-1:0]          row_index,
    output logic signed [ENTRY_W-1:0] sub_entry,
    output logic signed [ENTRY_W-1:0] diag_entry,
    output logic signed [ENTRY_W-1:0] super_entry,
    output logic                      spacing_error,
    output logic                      last_row
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    fdra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdra_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .grid_point    (grid_point),
        .last_point    (last_point),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .row_index     (row_index),
        .sub_entry     (sub_entry),
        .diag_entry    (diag_entry),
        .super_entry   (super_entry),
        .spacing_error (spacing_error),
        .last_row      (last_row)
    );

    // taking a new node means the previous row word has gone
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a row word is pending");

    // the final row of a grid hands straight back to the input side
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_row |=> in_ready)
        else $error("block not idle after final row");

    // neither divider is ever restarted mid-division
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.div_idle)
        else $error("divider started while busy");

endmodule
